FILE: sv/ghst_pkg.sv
// Shared types, constants and codes of the generational handle slot table.
package ghst_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int REF_WIDTH  = 64;

	localparam int CMD_W = 2;
	localparam int OBJ_W = 64;
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int GEN_W = 32;
	localparam int CNT_W = IDX_W + 1;
	localparam int STS_W = 2;

	localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);
	localparam logic [GEN_W-1:0] GEN_MAX    = '1;
	localparam logic [GEN_W-1:0] GEN_FIRST  = GEN_W'(1);

	// command codes
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESOLVE  = 2'd2;

	// status codes
	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_NULL = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL = 2'd2;
	localparam logic [STS_W-1:0] STS_BAD  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [OBJ_W-1:0] object_ref;
		logic             take_ownership;
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
	} item_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] out_index;
		logic [GEN_W-1:0] out_generation;
		logic [OBJ_W-1:0] resolved_ref;
		logic             destroy_request;
		logic [CNT_W-1:0] live_count;
	} result_t;

	// one slot: stored reference, ownership flag, current generation
	typedef struct packed {
		logic [REF_WIDTH-1:0] obj;
		logic                 owned;
		logic [GEN_W-1:0]     gen;
	} slot_t;

	// one free stack entry: released index with the generation it will reuse
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} stk_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

FILE: sv/generational_handle_slot_table.sv
// Top level of the generational handle slot table: controller plus datapath.
//
// Usage:
//   Drive item (command, reference, ownership flag, handle) and raise start.
//   The command transfers at the rising edge where start is high and busy low.
//   Register stores a nonzero reference and returns a handle (index and
//   generation); release checks the handle, clears the slot, bumps its
//   generation and asks for destruction of an owned reference; resolve
//   returns the stored reference for a live handle.
// Timing:
//   Commands never overlap. The accept edge launches the registered reads
//   of the slot memory and the free stack memory; the next cycle evaluates the
//   command and writes both memories back; the result then stands on result
//   for exactly one cycle with done high. busy is high during that execute
//   cycle, and a new command may transfer in the cycle the result is shown.
//   The read-modify-write through the registered memory port sets the rate.
// Reset:
//   arst_n clears the controller and the free, grown and live counters; the
//   memories need no clearing since only written entries are ever used.
// Results cannot be held off: sample result whenever done is high.
module generational_handle_slot_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ghst_pkg::item_t   item,
	output logic              done,
	output ghst_pkg::result_t result
);

	import ghst_pkg::*;

	ctrl_cmd_t cmd;

	// sequence each command: capture, then one execute cycle
	ghst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// hold the memories and counters, evaluate and register the result
	ghst_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.done   (done),
		.result (result)
	);

endmodule

FILE: sv/ghst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ghst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ghst_ctrl.sv
// Controller state machine: accept a command, then execute it for one cycle.
module ghst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output ghst_pkg::ctrl_cmd_t cmd
);

	import ghst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_IDLE)
		else $error("execute phase lasted more than one cycle");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_EXEC)
		else $error("accepted command was not executed");

	a_no_double_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.execute))
		else $error("capture and execute in the same cycle");

endmodule

FILE: sv/ghst_datapath.sv
// Datapath: slot and free stack memories, counters, command evaluation, result register.
module ghst_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ghst_pkg::ctrl_cmd_t cmd,
	input  ghst_pkg::item_t     item,
	output logic                done,
	output ghst_pkg::result_t   result
);

	import ghst_pkg::*;

	item_t            req_q;
	logic [CNT_W-1:0] free_depth_q, free_depth_d;
	logic [CNT_W-1:0] grown_q, grown_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	result_t          res_q, res_d;
	logic             done_q;

	logic             slot_we;
	logic [IDX_W-1:0] slot_waddr;
	slot_t            slot_wdata;
	slot_t            slot_rdata;

	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr;
	stk_t             stk_wdata;
	stk_t             stk_rdata;
	logic [CNT_W-1:0] stk_top;

	logic [REF_WIDTH-1:0] oref;
	logic                 live;
	logic [GEN_W-1:0]     gen_next;

	// read at the accept edge so the words are ready during execute
	assign stk_top = free_depth_q - CNT_W'(1);

	ghst_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (item.handle_index),
		.rdata (slot_rdata)
	);

	ghst_ram #(.WIDTH($bits(stk_t)), .DEPTH(SLOT_COUNT)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_top[IDX_W-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= item;
		end
		if (cmd.execute) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			grown_q      <= '0;
			occ_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.execute) begin
				free_depth_q <= free_depth_d;
				grown_q      <= grown_d;
				occ_q        <= occ_d;
			end
		end
	end

	assign oref     = req_q.object_ref[REF_WIDTH-1:0];
	assign live     = ({1'b0, req_q.handle_index} < grown_q)
	               && (slot_rdata.gen == req_q.handle_generation)
	               && (slot_rdata.obj != '0);
	assign gen_next = (slot_rdata.gen == GEN_MAX) ? GEN_FIRST : slot_rdata.gen + GEN_FIRST;

	always_comb begin
		res_d        = '0;
		free_depth_d = free_depth_q;
		grown_d      = grown_q;
		occ_d        = occ_q;
		slot_we      = 1'b0;
		slot_waddr   = req_q.handle_index;
		slot_wdata   = '0;
		stk_we       = 1'b0;
		stk_waddr    = free_depth_q[IDX_W-1:0];
		stk_wdata    = '0;
		case (req_q.command)
			CMD_REGISTER: begin
				if (oref == '0) begin
					res_d.status = STS_NULL;
				end else if (free_depth_q != '0) begin
					// reuse the most recently released slot
					free_depth_d         = stk_top;
					slot_we              = cmd.execute;
					slot_waddr           = stk_rdata.idx;
					slot_wdata           = '{obj: oref, owned: req_q.take_ownership,
						gen: stk_rdata.gen};
					occ_d                = occ_q + CNT_W'(1);
					res_d.out_index      = stk_rdata.idx;
					res_d.out_generation = stk_rdata.gen;
				end else if (grown_q < SLOT_LIMIT) begin
					grown_d              = grown_q + CNT_W'(1);
					slot_we              = cmd.execute;
					slot_waddr           = grown_q[IDX_W-1:0];
					slot_wdata           = '{obj: oref, owned: req_q.take_ownership,
						gen: GEN_FIRST};
					occ_d                = occ_q + CNT_W'(1);
					res_d.out_index      = grown_q[IDX_W-1:0];
					res_d.out_generation = GEN_FIRST;
				end else begin
					res_d.status = STS_FULL;
				end
			end
			CMD_RELEASE: begin
				if (!live) begin
					res_d.status = STS_BAD;
				end else begin
					if (slot_rdata.owned) begin
						res_d.resolved_ref    = OBJ_W'(slot_rdata.obj);
						res_d.destroy_request = 1'b1;
					end
					slot_we    = cmd.execute;
					slot_wdata = '{obj: '0, owned: 1'b0, gen: gen_next};
					if (free_depth_q < SLOT_LIMIT) begin
						stk_we       = cmd.execute;
						stk_wdata    = '{idx: req_q.handle_index, gen: gen_next};
						free_depth_d = free_depth_q + CNT_W'(1);
					end
					if (occ_q != '0) begin
						occ_d = occ_q - CNT_W'(1);
					end
				end
			end
			CMD_RESOLVE: begin
				if (!live) begin
					res_d.status = STS_BAD;
				end else begin
					res_d.resolved_ref = OBJ_W'(slot_rdata.obj);
				end
			end
			default: begin
				res_d.status = STS_BAD;
			end
		endcase
		res_d.live_count = occ_d;
	end

	assign done   = done_q;
	assign result = res_q;

	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(free_depth_q + occ_q) == grown_q)
		else $error("free and occupied slots do not add up to grown slots");

	a_grown_bound: assert property (@(posedge clk) disable iff (!arst_n)
		grown_q <= SLOT_LIMIT)
		else $error("grown slot count beyond table size");

	a_destroy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.destroy_request |-> res_q.status == STS_OK && res_q.resolved_ref != '0)
		else $error("destroy request without a successful release");

	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> done_q)
		else $error("executed command produced no result strobe");

endmodule

FILE: dv/generational_handle_slot_table_checker.sv
// Checker for the handle slot table: predicts every transfer and compares each result.
module generational_handle_slot_table_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ghst_pkg::item_t   item,
	input  logic              done,
	input  ghst_pkg::result_t result,
	output int                fail_count,
	output int                pending_count
);
	import ghst_pkg::*;

	// shadow copy of the table
	logic [REF_WIDTH-1:0] ref_store [SLOT_COUNT];
	logic                 owned_store [SLOT_COUNT];
	logic [GEN_W-1:0]     gen_store [SLOT_COUNT];
	logic [IDX_W-1:0]     free_list [SLOT_COUNT];
	int unsigned          free_top;
	int unsigned          grown;
	int unsigned          live_slots;

	result_t predicted_replies[$];
	result_t want;
	int      errors = 0;
	int      reports = 0;

	// a handle is live when its slot was grown, the generation matches and the slot holds a reference
	function automatic logic handle_ok(input item_t req);
		if (req.handle_index >= grown)
			return 1'b0;
		if (gen_store[req.handle_index] != req.handle_generation)
			return 1'b0;
		return ref_store[req.handle_index] != '0;
	endfunction

	function automatic result_t table_step(input item_t req);
		result_t          r;
		logic [OBJ_W-1:0] obj;
		int unsigned      slot;
		logic             granted;
		r = '0;
		slot = 0;
		obj = OBJ_W'(req.object_ref[REF_WIDTH-1:0]);
		case (req.command)
			CMD_REGISTER: begin
				granted = 1'b1;
				if (obj == '0) begin
					r.status = STS_NULL;
					granted = 1'b0;
				end else if (free_top > 0) begin
					free_top--;
					slot = free_list[free_top];
				end else if (grown < SLOT_COUNT) begin
					slot = grown;
					grown++;
					gen_store[slot] = GEN_FIRST;
				end else begin
					r.status = STS_FULL;
					granted = 1'b0;
				end
				if (granted) begin
					ref_store[slot] = obj[REF_WIDTH-1:0];
					owned_store[slot] = req.take_ownership;
					live_slots++;
					r.out_index = IDX_W'(slot);
					r.out_generation = gen_store[slot];
				end
			end
			CMD_RELEASE: begin
				if (!handle_ok(req)) begin
					r.status = STS_BAD;
				end else begin
					slot = req.handle_index;
					if (owned_store[slot]) begin
						r.resolved_ref = OBJ_W'(ref_store[slot]);
						r.destroy_request = 1'b1;
					end
					ref_store[slot] = '0;
					owned_store[slot] = 1'b0;
					gen_store[slot] = (gen_store[slot] == GEN_MAX) ? GEN_FIRST
						: gen_store[slot] + 1'b1;
					if (free_top < SLOT_COUNT) begin
						free_list[free_top] = req.handle_index;
						free_top++;
					end
					if (live_slots > 0)
						live_slots--;
				end
			end
			CMD_RESOLVE: begin
				if (!handle_ok(req))
					r.status = STS_BAD;
				else
					r.resolved_ref = OBJ_W'(ref_store[req.handle_index]);
			end
			default: r.status = STS_BAD;
		endcase
		r.live_count = CNT_W'(live_slots);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top = 0;
			grown = 0;
			live_slots = 0;
			predicted_replies.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			// retire the shown result before queuing a transfer of the same edge
			if (done === 1'b1) begin
				if (predicted_replies.size() == 0) begin
					errors++;
					if (reports < 10) begin
						$display("unexpected result: st=%0d idx=%0d gen=%h ref=%h dr=%0d live=%0d",
							result.status, result.out_index, result.out_generation,
							result.resolved_ref, result.destroy_request, result.live_count);
						reports++;
					end
				end else begin
					want = predicted_replies.pop_front();
					if (result.status !== want.status
							|| result.out_index !== want.out_index
							|| result.out_generation !== want.out_generation
							|| result.resolved_ref !== want.resolved_ref
							|| result.destroy_request !== want.destroy_request
							|| result.live_count !== want.live_count) begin
						errors++;
						if (reports < 10) begin
							$display("result mismatch exp: st=%0d idx=%0d gen=%h ref=%h dr=%0d live=%0d",
								want.status, want.out_index, want.out_generation,
								want.resolved_ref, want.destroy_request, want.live_count);
							$display("                got: st=%0d idx=%0d gen=%h ref=%h dr=%0d live=%0d",
								result.status, result.out_index, result.out_generation,
								result.resolved_ref, result.destroy_request, result.live_count);
							reports++;
						end
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				predicted_replies.insert(predicted_replies.size(), table_step(item));
			fail_count <= errors + predicted_replies.size();
			pending_count <= predicted_replies.size();
		end
	end

endmodule

FILE: dv/generational_handle_slot_table_tb.sv
// Testbench top for the handle slot table: clock, reset, command stimulus and verdict.
module generational_handle_slot_table_tb;
	import ghst_pkg::*;

	// command code the block does not know
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	// cycles without any transfer or result before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// number of table-full results to collect before leaving the fill phase
	localparam int FULL_GOAL = 12;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} handle_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;
	int      fail_count;
	int      pending_count;

	// handles handed out by the block, and handles already released
	handle_t live_handles[$];
	handle_t retired_handles[$];
	int      full_seen = 0;
	int      idle_cycles = 0;
	int      burst_left = 0;

	generational_handle_slot_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	generational_handle_slot_table_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.done          (done),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Harvest handles from results so later releases and resolves can aim at live slots.
	// A successful register is the only result that carries a nonzero generation.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (result.status == STS_OK && result.out_generation != '0)
				live_handles.insert(live_handles.size(),
					handle_t'{idx: result.out_index, gen: result.out_generation});
			if (result.status == STS_FULL)
				full_seen++;
		end
	end

	// Watchdog: restart the count on every transfer or result, end the run when it runs out.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic item_t make_item(input logic [CMD_W-1:0] cmd, input logic [OBJ_W-1:0] obj,
			input logic own, input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen);
		item_t it;
		it.command = cmd;
		it.object_ref = obj;
		it.take_ownership = own;
		it.handle_index = idx;
		it.handle_generation = gen;
		return it;
	endfunction

	// every field random, so unused fields toggle as well
	function automatic item_t random_item();
		item_t it;
		it.command = CMD_W'($urandom);
		it.object_ref = {$urandom, $urandom};
		it.take_ownership = 1'($urandom);
		it.handle_index = IDX_W'($urandom);
		it.handle_generation = $urandom;
		return it;
	endfunction

	// mostly full-width random references, now and then the corner shapes
	function automatic logic [OBJ_W-1:0] random_ref();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return OBJ_W'(1) << $urandom_range(0, OBJ_W - 1);
			2: return OBJ_W'($urandom_range(1, 255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Hold off for a random gap (none inside a burst), then present the item
	// and hold start until the transfer happens. Start is lowered only when a gap follows,
	// so back-to-back items keep start high with a single assignment per edge.
	task automatic transfer_item(input item_t it);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 7);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(8, 24);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic issue_register();
		item_t it;
		it = random_item();
		it.command = CMD_REGISTER;
		it.object_ref = random_ref();
		transfer_item(it);
	endtask

	// release a known live handle and remember it as stale afterwards
	task automatic issue_release();
		item_t   it;
		handle_t h;
		int      pos;
		it = random_item();
		it.command = CMD_RELEASE;
		if (live_handles.size() > 0) begin
			pos = $urandom_range(0, live_handles.size() - 1);
			h = live_handles[pos];
			live_handles.delete(pos);
			retired_handles.insert(retired_handles.size(), h);
			if (retired_handles.size() > 32)
				void'(retired_handles.pop_front());
			it.handle_index = h.idx;
			it.handle_generation = h.gen;
		end
		transfer_item(it);
	endtask

	task automatic issue_resolve();
		item_t   it;
		handle_t h;
		it = random_item();
		it.command = CMD_RESOLVE;
		if (live_handles.size() > 0) begin
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
			it.handle_index = h.idx;
			it.handle_generation = h.gen;
		end
		transfer_item(it);
	endtask

	// malformed traffic: unknown codes, null references, stale and forged handles
	task automatic issue_noise();
		item_t   it;
		handle_t h;
		it = random_item();
		case ($urandom_range(0, 5))
			0: it.command = CMD_UNKNOWN;
			1: begin
				it.command = CMD_REGISTER;
				it.object_ref = '0;
			end
			2: it.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_RESOLVE;
			3: begin
				it.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_RESOLVE;
				if (retired_handles.size() > 0) begin
					h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
					it.handle_index = h.idx;
					it.handle_generation = h.gen;
				end
			end
			4: begin
				it.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_RESOLVE;
				if (live_handles.size() > 0) begin
					h = live_handles[$urandom_range(0, live_handles.size() - 1)];
					it.handle_index = h.idx;
					case ($urandom_range(0, 2))
						0: it.handle_generation = h.gen + 1'b1;
						1: it.handle_generation = h.gen - 1'b1;
						default: it.handle_generation = '0;
					endcase
				end
			end
			default: begin
				// first generation at any index: catches indices past the grown region
				it.command = CMD_RESOLVE;
				it.handle_generation = GEN_FIRST;
			end
		endcase
		transfer_item(it);
	endtask

	// weighted mix of commands; the remainder of the percentages goes to noise
	task automatic run_mix(input int count, input int reg_pct, input int rel_pct,
			input int res_pct, input bit stop_on_full);
		int roll;
		for (int n = 0; n < count; n++) begin
			if (stop_on_full && full_seen >= FULL_GOAL)
				break;
			roll = $urandom_range(0, 99);
			if (roll < reg_pct)
				issue_register();
			else if (roll < reg_pct + rel_pct)
				issue_release();
			else if (roll < reg_pct + rel_pct + res_pct)
				issue_resolve();
			else
				issue_noise();
		end
	endtask

	initial begin
		// hold reset, then release it on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; handles follow from a fresh table
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd0, GEN_FIRST));     // empty table
		transfer_item(make_item(CMD_REGISTER, '0, 1'b1, 8'hFF, '1));          // null reference
		transfer_item(make_item(CMD_REGISTER, '1, 1'b1, 8'd0, '0));           // grows slot 0
		transfer_item(make_item(CMD_REGISTER, 64'h1, 1'b0, 8'hFF, '1));       // grows slot 1
		transfer_item(make_item(CMD_REGISTER, 64'h8000_0000_0000_0000, 1'b1,
			8'd0, '0));                                                       // grows slot 2
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd0, 32'd1));         // live
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd1, 32'd2));         // wrong generation
		transfer_item(make_item(CMD_RESOLVE, '1, 1'b1, 8'd2, '1));            // wrong generation
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'hFF, 32'd1));        // index not grown
		transfer_item(make_item(CMD_RELEASE, '0, 1'b0, 8'd1, 32'd1));         // unowned release
		transfer_item(make_item(CMD_RELEASE, '0, 1'b0, 8'd1, 32'd1));         // stale release
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd1, 32'd2));         // empty slot, gen match
		transfer_item(make_item(CMD_RELEASE, '0, 1'b0, 8'd0, 32'd1));         // owned release
		transfer_item(make_item(CMD_REGISTER, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0,
			8'd0, '0));                                                       // reuses slot 0
		transfer_item(make_item(CMD_REGISTER, 64'h5A5A_A5A5_F0F0_0F0F, 1'b1,
			8'd0, '0));                                                       // reuses slot 1
		transfer_item(make_item(CMD_REGISTER, 64'hDEAD_0000_BEEF, 1'b1,
			8'd0, '0));                                                       // grows slot 3
		transfer_item(make_item(CMD_UNKNOWN, '1, 1'b1, 8'hFF, '1));           // unknown command
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd0, '0));            // generation zero
		transfer_item(make_item(CMD_RESOLVE, '0, 1'b0, 8'd0, 32'd2));         // reused live slot
		transfer_item(make_item(CMD_RELEASE, '0, 1'b0, 8'd2, 32'd1));         // owned, top bit set
		transfer_item(make_item(CMD_RELEASE, '0, 1'b0, 8'd0, '1));            // wrong generation
		transfer_item(make_item(CMD_RELEASE, '0, 1'b1, 8'd3, 32'd1));         // owned release

		// mixed traffic, then fill the table until it reports full, then drain it
		run_mix(180, 45, 25, 15, 1'b0);
		run_mix(600, 85, 0, 10, 1'b1);
		run_mix(170, 15, 65, 12, 1'b0);

		// drop start after the last transfer and wait out the outstanding results
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
